>>> rtl/gitlf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gitlf_pkg
// Shared types and constants for the track label fusion block.
// ----------------------------------------------------------------------------
package gitlf_pkg;

   localparam int ID_W       = 8;
   localparam int CLASS_W    = 8;
   localparam int SCORE_W    = 16;
   localparam int COORD_IN_W = 12;
   localparam int MATCH_W    = 5;
   localparam int FRAC_W     = 16;

   localparam logic [SCORE_W-1:0] THR_RESET = 16'd9830;

   localparam logic [1:0] KIND_TRACK = 2'd0;
   localparam logic [1:0] KIND_DET   = 2'd1;
   localparam logic [1:0] KIND_EOF   = 2'd2;
   localparam logic [1:0] KIND_BATCH = 2'd3;

   localparam logic REPORT_LIVE   = 1'b0;
   localparam logic REPORT_VANISH = 1'b1;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SCAN_RD,
      ST_SCAN_WR,
      ST_PASS,
      ST_PAIR,
      ST_OVL,
      ST_INT,
      ST_AREA,
      ST_UNION_A,
      ST_UNION_B,
      ST_THR,
      ST_OK,
      ST_CMP_B,
      ST_CMP_C,
      ST_COMMIT,
      ST_REP_RD,
      ST_REP_WR,
      ST_FLUSH
   } state_type;

   typedef enum logic [2:0] {
      MUL_NONE,
      MUL_INTER,
      MUL_AREA_T,
      MUL_AREA_D,
      MUL_THR,
      MUL_CMP_A,
      MUL_CMP_B
   } mul_sel_type;

   typedef struct packed {
      logic        idle;
      logic        clr_wr;
      logic        id_inc;
      logic        lm_rd;
      logic        scan_wr;
      logic        emit;
      logic        match_init;
      logic        pass_init;
      logic        pair_next;
      logic        ovl_en;
      mul_sel_type mul_sel;
      logic        inter_en;
      logic        area_en;
      logic        union_en;
      logic        cmp_save;
      logic        take_best;
      logic        commit;
      logic        rep_init;
      logic        rep_rd;
      logic        rep_wr;
      logic        rep_next;
      logic        flush;
      logic        frame_done;
   } cmd_type;

   typedef struct packed {
      logic eof_req;
      logic id_last;
      logic vanish;
      logic out_free;
      logic no_pairs;
      logic row_end;
      logic pair_skip;
      logic found;
      logic pair_ok;
      logic better;
      logic pend_valid;
   } status_type;

endpackage

>>> rtl/gitlf_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gitlf_ram
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
module gitlf_ram #(
   parameter int WIDTH = 26,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/gitlf_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gitlf_ctrl
// Sequencer: label clear, loading, vanish scan, greedy matching, reporting.
// ----------------------------------------------------------------------------
module gitlf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  gitlf_pkg::status_type  status,
   output gitlf_pkg::cmd_type     cmd
);
   import gitlf_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.id_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (status.eof_req) state_in = ST_SCAN_RD;
         end
         ST_SCAN_RD: state_in = ST_SCAN_WR;
         ST_SCAN_WR: begin
            if (!status.vanish || status.out_free) begin
               state_in = status.id_last ? ST_PASS : ST_SCAN_RD;
            end
         end
         ST_PASS: state_in = status.no_pairs ? ST_REP_RD : ST_PAIR;
         ST_PAIR: begin
            if (status.row_end) begin
               state_in = status.found ? ST_COMMIT : ST_REP_RD;
            end else if (!status.pair_skip) begin
               state_in = ST_OVL;
            end
         end
         ST_OVL:     state_in = ST_INT;
         ST_INT:     state_in = ST_AREA;
         ST_AREA:    state_in = ST_UNION_A;
         ST_UNION_A: state_in = ST_UNION_B;
         ST_UNION_B: state_in = ST_THR;
         ST_THR:     state_in = ST_OK;
         ST_OK: begin
            state_in = (status.pair_ok && status.found) ? ST_CMP_B : ST_PAIR;
         end
         ST_CMP_B:   state_in = ST_CMP_C;
         ST_CMP_C:   state_in = ST_PAIR;
         ST_COMMIT:  state_in = ST_PASS;
         ST_REP_RD:  state_in = status.row_end ? ST_FLUSH : ST_REP_WR;
         ST_REP_WR: begin
            if (status.out_free) state_in = ST_REP_RD;
         end
         ST_FLUSH: begin
            if (!status.pend_valid || status.out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      cmd.mul_sel = MUL_NONE;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clr_wr = 1'b1;
            cmd.id_inc = 1'b1;
         end
         ST_IDLE:    cmd.idle = 1'b1;
         ST_SCAN_RD: cmd.lm_rd = 1'b1;
         ST_SCAN_WR: begin
            if (!status.vanish || status.out_free) begin
               cmd.scan_wr    = 1'b1;
               cmd.emit       = status.vanish;
               cmd.id_inc     = 1'b1;
               cmd.match_init = status.id_last;
            end
         end
         ST_PASS: begin
            cmd.rep_init  = status.no_pairs;
            cmd.pass_init = !status.no_pairs;
         end
         ST_PAIR: begin
            if (status.row_end) begin
               cmd.rep_init = !status.found;
            end else begin
               cmd.pair_next = status.pair_skip;
            end
         end
         ST_OVL: cmd.ovl_en = 1'b1;
         ST_INT: cmd.mul_sel = MUL_INTER;
         ST_AREA: begin
            cmd.inter_en = 1'b1;
            cmd.mul_sel  = MUL_AREA_T;
         end
         ST_UNION_A: begin
            cmd.area_en = 1'b1;
            cmd.mul_sel = MUL_AREA_D;
         end
         ST_UNION_B: cmd.union_en = 1'b1;
         ST_THR:     cmd.mul_sel = MUL_THR;
         ST_OK: begin
            if (!status.pair_ok) begin
               cmd.pair_next = 1'b1;
            end else if (!status.found) begin
               cmd.take_best = 1'b1;
               cmd.pair_next = 1'b1;
            end else begin
               cmd.mul_sel = MUL_CMP_A;
            end
         end
         ST_CMP_B: begin
            cmd.cmp_save = 1'b1;
            cmd.mul_sel  = MUL_CMP_B;
         end
         ST_CMP_C: begin
            cmd.take_best = status.better;
            cmd.pair_next = 1'b1;
         end
         ST_COMMIT: cmd.commit = 1'b1;
         ST_REP_RD: cmd.rep_rd = !status.row_end;
         ST_REP_WR: begin
            if (status.out_free) begin
               cmd.rep_wr   = 1'b1;
               cmd.emit     = 1'b1;
               cmd.rep_next = 1'b1;
            end
         end
         ST_FLUSH: begin
            if (!status.pend_valid) begin
               cmd.frame_done = 1'b1;
            end else if (status.out_free) begin
               cmd.flush      = 1'b1;
               cmd.frame_done = 1'b1;
            end
         end
         default: cmd.idle = 1'b0;
      endcase
   end

endmodule

>>> rtl/gitlf_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gitlf_dp
// Box stores, label memory, shared IoU multiplier and result staging.
// ----------------------------------------------------------------------------
module gitlf_dp #(
   parameter int MAX_TRACKS = 16,
   parameter int MAX_DETS   = 16,
   parameter int ID_COUNT   = 256,
   parameter int COORD_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  gitlf_pkg::cmd_type                  cmd,
   output gitlf_pkg::status_type               status,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_kind,
   input  logic [gitlf_pkg::COORD_IN_W-1:0]    req_box_left,
   input  logic [gitlf_pkg::COORD_IN_W-1:0]    req_box_top,
   input  logic [gitlf_pkg::COORD_IN_W-1:0]    req_box_width,
   input  logic [gitlf_pkg::COORD_IN_W-1:0]    req_box_height,
   input  logic                                req_has_box,
   input  logic [gitlf_pkg::ID_W-1:0]          req_track_id,
   input  logic [gitlf_pkg::CLASS_W-1:0]       req_class_code,
   input  logic [gitlf_pkg::SCORE_W-1:0]       req_det_score,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_report_kind,
   output logic [gitlf_pkg::ID_W-1:0]          rsp_out_track_id,
   output logic                                rsp_identified,
   output logic [gitlf_pkg::CLASS_W-1:0]       rsp_out_class,
   output logic [gitlf_pkg::SCORE_W-1:0]       rsp_out_score,
   output logic [gitlf_pkg::MATCH_W-1:0]       rsp_matched_det,
   output logic                                rsp_overflowed,
   output logic                                rsp_last,
   input  logic                                csr_write,
   input  logic [gitlf_pkg::SCORE_W-1:0]       csr_data
);
   import gitlf_pkg::*;

   localparam int TCW  = $clog2(MAX_TRACKS + 1);
   localparam int TIW  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
   localparam int DCW  = $clog2(MAX_DETS + 1);
   localparam int DIW  = (MAX_DETS > 1) ? $clog2(MAX_DETS) : 1;
   localparam int IDW  = $clog2(ID_COUNT);
   localparam int C    = COORD_BITS;
   localparam int AW   = 2 * C;
   localparam int UW   = 2 * C + 1;
   localparam int PW   = 2 * UW;
   localparam int LM_W = 2 + CLASS_W + SCORE_W;
   localparam logic [DCW-1:0] DET_NONE = DCW'(MAX_DETS);

   // track_id folded onto the label memory range
   function automatic logic [IDW-1:0] id_fold(input logic [ID_W-1:0] id);
      logic [16:0] v;
      v = 17'(id);
      for (int k = 3; k >= 0; k--) begin
         if (v >= 17'(ID_COUNT << k)) v = v - 17'(ID_COUNT << k);
      end
      return IDW'(v);
   endfunction

   function automatic logic [C-1:0] span(input logic [C:0] a0, input logic [C:0] a1,
                                         input logic [C:0] b0, input logic [C:0] b1);
      logic [C:0] lo;
      logic [C:0] hi;
      lo = (a0 > b0) ? a0 : b0;
      hi = (a1 < b1) ? a1 : b1;
      return (hi > lo) ? C'(hi - lo) : '0;
   endfunction

   // box stores
   logic [C-1:0]       trk_l_ff [MAX_TRACKS];
   logic [C-1:0]       trk_t_ff [MAX_TRACKS];
   logic [C-1:0]       trk_w_ff [MAX_TRACKS];
   logic [C-1:0]       trk_h_ff [MAX_TRACKS];
   logic               trk_has_ff [MAX_TRACKS];
   logic [ID_W-1:0]    trk_id_ff [MAX_TRACKS];
   logic [IDW-1:0]     trk_idx_ff [MAX_TRACKS];
   logic [C-1:0]       det_l_ff [MAX_DETS];
   logic [C-1:0]       det_t_ff [MAX_DETS];
   logic [C-1:0]       det_w_ff [MAX_DETS];
   logic [C-1:0]       det_h_ff [MAX_DETS];
   logic [CLASS_W-1:0] det_class_ff [MAX_DETS];
   logic [SCORE_W-1:0] det_score_ff [MAX_DETS];
   logic [DCW-1:0]     assign_ff [MAX_TRACKS];
   logic [MAX_DETS-1:0] used_ff;

   logic [TCW-1:0]     trk_cnt_ff;
   logic [DCW-1:0]     det_cnt_ff;
   logic               ovf_ff;
   logic [SCORE_W-1:0] thr_ff;
   logic [IDW-1:0]     id_cnt_ff;
   logic [TCW-1:0]     i_ff;
   logic [DCW-1:0]     j_ff;

   logic               found_ff;
   logic [TCW-1:0]     best_i_ff;
   logic [DCW-1:0]     best_j_ff;
   logic [AW-1:0]      best_inter_ff;
   logic [UW-1:0]      best_union_ff;
   logic [C-1:0]       ix_ff, iy_ff;
   logic [PW-1:0]      prod_ff, p1_ff;
   logic [AW-1:0]      inter_ff, area_ff;
   logic [UW-1:0]      union_ff;

   logic               pend_valid_ff;
   logic               pend_kind_ff;
   logic [ID_W-1:0]    pend_id_ff;
   logic               pend_ident_ff;
   logic [CLASS_W-1:0] pend_class_ff;
   logic [SCORE_W-1:0] pend_score_ff;
   logic [MATCH_W-1:0] pend_det_ff;
   logic               pend_ovf_ff;

   logic               rsp_valid_ff;
   logic               rsp_kind_ff;
   logic [ID_W-1:0]    rsp_id_ff;
   logic               rsp_ident_ff;
   logic [CLASS_W-1:0] rsp_class_ff;
   logic [SCORE_W-1:0] rsp_score_ff;
   logic [MATCH_W-1:0] rsp_det_ff;
   logic               rsp_ovf_ff;
   logic               rsp_last_ff;

   logic               accept, trk_full, det_full, trk_wr, det_wr;
   logic [TIW-1:0]     ti;
   logic [DIW-1:0]     dj;
   logic               live, vanish, out_free, out_load, id_last;
   logic [LM_W-1:0]    lm_rd_data, lm_wr_data, rep_entry;
   logic               lm_wr_en, lm_rd_en;
   logic [IDW-1:0]     lm_wr_addr, lm_rd_addr;
   logic [DCW-1:0]     rep_d;
   logic [DIW-1:0]     rep_di;
   logic               rep_upd;
   logic [UW-1:0]      op_a, op_b;
   logic               pair_ok, better;

   assign accept   = cmd.idle && req_valid;
   assign trk_full = trk_cnt_ff >= TCW'(MAX_TRACKS);
   assign det_full = det_cnt_ff >= DCW'(MAX_DETS);
   assign trk_wr   = accept && (req_kind == KIND_TRACK) && !trk_full;
   assign det_wr   = accept && (req_kind == KIND_DET) && !det_full;
   assign ti       = i_ff[TIW-1:0];
   assign dj       = j_ff[DIW-1:0];
   assign id_last  = id_cnt_ff == IDW'(ID_COUNT - 1);

   always_ff @(posedge clock) begin
      if (trk_wr) begin
         trk_l_ff[trk_cnt_ff[TIW-1:0]]   <= C'(req_box_left);
         trk_t_ff[trk_cnt_ff[TIW-1:0]]   <= C'(req_box_top);
         trk_w_ff[trk_cnt_ff[TIW-1:0]]   <= C'(req_box_width);
         trk_h_ff[trk_cnt_ff[TIW-1:0]]   <= C'(req_box_height);
         trk_has_ff[trk_cnt_ff[TIW-1:0]] <= req_has_box;
         trk_id_ff[trk_cnt_ff[TIW-1:0]]  <= req_track_id;
         trk_idx_ff[trk_cnt_ff[TIW-1:0]] <= id_fold(req_track_id);
      end
      if (det_wr) begin
         det_l_ff[det_cnt_ff[DIW-1:0]]     <= C'(req_box_left);
         det_t_ff[det_cnt_ff[DIW-1:0]]     <= C'(req_box_top);
         det_w_ff[det_cnt_ff[DIW-1:0]]     <= C'(req_box_width);
         det_h_ff[det_cnt_ff[DIW-1:0]]     <= C'(req_box_height);
         det_class_ff[det_cnt_ff[DIW-1:0]] <= req_class_code;
         det_score_ff[det_cnt_ff[DIW-1:0]] <= req_det_score;
      end
      if (cmd.match_init) begin
         for (int t = 0; t < MAX_TRACKS; t++) begin
            assign_ff[t] <= DET_NONE;
         end
      end else if (cmd.commit) begin
         assign_ff[best_i_ff[TIW-1:0]] <= best_j_ff;
      end
   end

   // counters and control flags
   always_ff @(posedge clock) begin
      if (reset) begin
         trk_cnt_ff    <= '0;
         det_cnt_ff    <= '0;
         ovf_ff        <= 1'b0;
         thr_ff        <= THR_RESET;
         id_cnt_ff     <= '0;
         i_ff          <= '0;
         j_ff          <= '0;
         found_ff      <= 1'b0;
         used_ff       <= '0;
      end else begin
         if (csr_write) thr_ff <= csr_data;
         if (cmd.frame_done) begin
            trk_cnt_ff <= '0;
            ovf_ff     <= 1'b0;
         end else begin
            if (trk_wr) trk_cnt_ff <= trk_cnt_ff + TCW'(1);
            if (accept && (((req_kind == KIND_TRACK) && trk_full) ||
                           ((req_kind == KIND_DET) && det_full))) begin
               ovf_ff <= 1'b1;
            end
         end
         if (det_wr) begin
            det_cnt_ff <= det_cnt_ff + DCW'(1);
         end else if (accept && (req_kind == KIND_BATCH)) begin
            det_cnt_ff <= '0;
         end
         if (cmd.id_inc) id_cnt_ff <= id_last ? '0 : id_cnt_ff + IDW'(1);
         if (cmd.pass_init || cmd.rep_init) begin
            i_ff <= '0;
            j_ff <= '0;
         end else if (cmd.pair_next) begin
            if ((j_ff + DCW'(1)) == det_cnt_ff) begin
               j_ff <= '0;
               i_ff <= i_ff + TCW'(1);
            end else begin
               j_ff <= j_ff + DCW'(1);
            end
         end else if (cmd.rep_next) begin
            i_ff <= i_ff + TCW'(1);
         end
         if (cmd.pass_init) begin
            found_ff <= 1'b0;
         end else if (cmd.take_best) begin
            found_ff <= 1'b1;
         end
         if (cmd.match_init) begin
            used_ff <= '0;
         end else if (cmd.commit) begin
            used_ff[best_j_ff[DIW-1:0]] <= 1'b1;
         end
      end
   end

   // label memory: {active, valid, class, score}
   always_comb begin
      live = 1'b0;
      for (int t = 0; t < MAX_TRACKS; t++) begin
         if ((TCW'(t) < trk_cnt_ff) && (trk_idx_ff[t] == id_cnt_ff)) live = 1'b1;
      end
   end

   assign vanish  = lm_rd_data[LM_W-1] && !live;
   assign rep_d   = assign_ff[ti];
   assign rep_di  = rep_d[DIW-1:0];
   assign rep_upd = (rep_d != DET_NONE) &&
                    (det_score_ff[rep_di] > lm_rd_data[SCORE_W-1:0]);
   assign rep_entry = rep_upd ?
                      {lm_rd_data[LM_W-1], 1'b1, det_class_ff[rep_di], det_score_ff[rep_di]} :
                      lm_rd_data;

   always_comb begin
      lm_wr_data = '0;
      if (cmd.scan_wr) begin
         lm_wr_data = vanish ? {live, (LM_W-1)'(0)} : {live, lm_rd_data[LM_W-2:0]};
      end else if (cmd.rep_wr) begin
         lm_wr_data = rep_entry;
      end
   end

   assign lm_wr_en   = cmd.clr_wr || cmd.scan_wr || cmd.rep_wr;
   assign lm_wr_addr = cmd.rep_wr ? trk_idx_ff[ti] : id_cnt_ff;
   assign lm_rd_en   = cmd.lm_rd || cmd.rep_rd;
   assign lm_rd_addr = cmd.rep_rd ? trk_idx_ff[ti] : id_cnt_ff;

   gitlf_ram #(
      .WIDTH (LM_W),
      .DEPTH (ID_COUNT)
   ) u_label_ram (
      .clock   (clock),
      .wr_en   (lm_wr_en),
      .wr_addr (lm_wr_addr),
      .wr_data (lm_wr_data),
      .rd_en   (lm_rd_en),
      .rd_addr (lm_rd_addr),
      .rd_data (lm_rd_data)
   );

   // IoU arithmetic around one shared multiplier
   always_comb begin
      op_a = '0;
      op_b = '0;
      case (cmd.mul_sel)
         MUL_INTER: begin
            op_a = UW'(ix_ff);
            op_b = UW'(iy_ff);
         end
         MUL_AREA_T: begin
            op_a = UW'(trk_w_ff[ti]);
            op_b = UW'(trk_h_ff[ti]);
         end
         MUL_AREA_D: begin
            op_a = UW'(det_w_ff[dj]);
            op_b = UW'(det_h_ff[dj]);
         end
         MUL_THR: begin
            op_a = UW'(thr_ff);
            op_b = union_ff;
         end
         MUL_CMP_A: begin
            op_a = UW'(inter_ff);
            op_b = best_union_ff;
         end
         MUL_CMP_B: begin
            op_a = UW'(best_inter_ff);
            op_b = union_ff;
         end
         default: begin
            op_a = '0;
            op_b = '0;
         end
      endcase
   end

   assign pair_ok = (PW'(inter_ff) << FRAC_W) > prod_ff;
   assign better  = p1_ff > prod_ff;

   always_ff @(posedge clock) begin
      if (cmd.ovl_en) begin
         ix_ff <= span({1'b0, trk_l_ff[ti]}, {1'b0, trk_l_ff[ti]} + {1'b0, trk_w_ff[ti]},
                       {1'b0, det_l_ff[dj]}, {1'b0, det_l_ff[dj]} + {1'b0, det_w_ff[dj]});
         iy_ff <= span({1'b0, trk_t_ff[ti]}, {1'b0, trk_t_ff[ti]} + {1'b0, trk_h_ff[ti]},
                       {1'b0, det_t_ff[dj]}, {1'b0, det_t_ff[dj]} + {1'b0, det_h_ff[dj]});
      end
      if (cmd.mul_sel != MUL_NONE) prod_ff <= PW'(op_a) * PW'(op_b);
      if (cmd.inter_en) inter_ff <= prod_ff[AW-1:0];
      if (cmd.area_en) area_ff <= prod_ff[AW-1:0];
      if (cmd.union_en) begin
         union_ff <= UW'(area_ff) + UW'(prod_ff[AW-1:0]) - UW'(inter_ff);
      end
      if (cmd.cmp_save) p1_ff <= prod_ff;
      if (cmd.take_best) begin
         best_i_ff     <= i_ff;
         best_j_ff     <= j_ff;
         best_inter_ff <= inter_ff;
         best_union_ff <= union_ff;
      end
   end

   // one result held back so the final one of a frame can be marked last
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign out_load = (cmd.emit && pend_valid_ff) || cmd.flush;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.emit) begin
            pend_valid_ff <= 1'b1;
         end else if (cmd.flush) begin
            pend_valid_ff <= 1'b0;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         pend_ovf_ff <= ovf_ff;
         if (cmd.scan_wr) begin
            pend_kind_ff  <= REPORT_VANISH;
            pend_id_ff    <= ID_W'(id_cnt_ff);
            pend_ident_ff <= 1'b0;
            pend_class_ff <= '0;
            pend_score_ff <= '0;
            pend_det_ff   <= MATCH_W'(DET_NONE);
         end else begin
            pend_kind_ff  <= REPORT_LIVE;
            pend_id_ff    <= trk_id_ff[ti];
            pend_ident_ff <= rep_entry[LM_W-2];
            pend_class_ff <= rep_entry[SCORE_W +: CLASS_W];
            pend_score_ff <= rep_entry[SCORE_W-1:0];
            pend_det_ff   <= MATCH_W'(rep_d);
         end
      end
      if (out_load) begin
         rsp_kind_ff  <= pend_kind_ff;
         rsp_id_ff    <= pend_id_ff;
         rsp_ident_ff <= pend_ident_ff;
         rsp_class_ff <= pend_class_ff;
         rsp_score_ff <= pend_score_ff;
         rsp_det_ff   <= pend_det_ff;
         rsp_ovf_ff   <= pend_ovf_ff;
         rsp_last_ff  <= cmd.flush;
      end
   end

   assign req_stall        = !cmd.idle;
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_report_kind  = rsp_kind_ff;
   assign rsp_out_track_id = rsp_id_ff;
   assign rsp_identified   = rsp_ident_ff;
   assign rsp_out_class    = rsp_class_ff;
   assign rsp_out_score    = rsp_score_ff;
   assign rsp_matched_det  = rsp_det_ff;
   assign rsp_overflowed   = rsp_ovf_ff;
   assign rsp_last         = rsp_last_ff;

   assign status.eof_req    = req_valid && (req_kind == KIND_EOF);
   assign status.id_last    = id_last;
   assign status.vanish     = vanish;
   assign status.out_free   = out_free;
   assign status.no_pairs   = (trk_cnt_ff == '0) || (det_cnt_ff == '0);
   assign status.row_end    = i_ff == trk_cnt_ff;
   assign status.pair_skip  = (assign_ff[ti] != DET_NONE) || used_ff[dj] || !trk_has_ff[ti];
   assign status.found      = found_ff;
   assign status.pair_ok    = pair_ok;
   assign status.better     = better;
   assign status.pend_valid = pend_valid_ff;

   a_out_room: assert property (@(posedge clock) disable iff (reset)
      out_load |-> out_free)
      else $error("result register overwritten while held");

   a_frame_clear: assert property (@(posedge clock) disable iff (reset)
      cmd.frame_done |=> (trk_cnt_ff == '0) && !ovf_ff)
      else $error("track list or overflow flag not cleared at end of frame");

   a_commit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> found_ff && !used_ff[best_j_ff[DIW-1:0]])
      else $error("detection assigned twice");

   a_flush_last: assert property (@(posedge clock) disable iff (reset)
      cmd.flush |=> rsp_valid_ff && rsp_last_ff && !pend_valid_ff)
      else $error("final item of frame not marked");

endmodule

>>> rtl/greedy_iou_track_label_fusion.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_iou_track_label_fusion
// Greedy IoU association of track boxes with detections, with label memory.
// ----------------------------------------------------------------------------
// Usage:
//  req_* carries one item per accept (valid high, stall low): track box,
//  detection box, end of frame or new detection batch. End of frame walks
//  the label memory, a read and a write per identity over all ID_COUNT ids,
//  then runs greedy passes: each pass visits every track/detection pair,
//  takes eligible ones through overlap, intersection, area, union, threshold
//  and, once a best pair is held, comparison steps (products on the single
//  shared multiplier), skips the rest; up to MAX_TRACKS+1 passes. Reports
//  follow, one per track. req_stall is high for the whole of that work.
//  rsp_* delivers results through an output register; rsp_stall holds it and
//  the sequencer waits. One result is held back until the next is known, so
//  the final one of a frame carries rsp_last.
//  csr_* writes the IoU threshold register; csr_ready is always high.
//  After reset the label memory is cleared, one entry a cycle, over all
//  ID_COUNT entries, during which req_stall stays high.
// ----------------------------------------------------------------------------
module greedy_iou_track_label_fusion #(
   parameter int MAX_TRACKS = 16,
   parameter int MAX_DETS   = 16,
   parameter int ID_COUNT   = 256,
   parameter int COORD_BITS = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [1:0]                          req_kind,
   input  logic [gitlf_pkg::COORD_IN_W-1:0]    req_box_left,
   input  logic [gitlf_pkg::COORD_IN_W-1:0]    req_box_top,
   input  logic [gitlf_pkg::COORD_IN_W-1:0]    req_box_width,
   input  logic [gitlf_pkg::COORD_IN_W-1:0]    req_box_height,
   input  logic                                req_has_box,
   input  logic [gitlf_pkg::ID_W-1:0]          req_track_id,
   input  logic [gitlf_pkg::CLASS_W-1:0]       req_class_code,
   input  logic [gitlf_pkg::SCORE_W-1:0]       req_det_score,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_report_kind,
   output logic [gitlf_pkg::ID_W-1:0]          rsp_out_track_id,
   output logic                                rsp_identified,
   output logic [gitlf_pkg::CLASS_W-1:0]       rsp_out_class,
   output logic [gitlf_pkg::SCORE_W-1:0]       rsp_out_score,
   output logic [gitlf_pkg::MATCH_W-1:0]       rsp_matched_det,
   output logic                                rsp_overflowed,
   output logic                                rsp_last,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [gitlf_pkg::SCORE_W-1:0]       csr_data
);
   import gitlf_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   gitlf_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .cmd    (cmd)
   );

   gitlf_dp #(
      .MAX_TRACKS (MAX_TRACKS),
      .MAX_DETS   (MAX_DETS),
      .ID_COUNT   (ID_COUNT),
      .COORD_BITS (COORD_BITS)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_kind         (req_kind),
      .req_box_left     (req_box_left),
      .req_box_top      (req_box_top),
      .req_box_width    (req_box_width),
      .req_box_height   (req_box_height),
      .req_has_box      (req_has_box),
      .req_track_id     (req_track_id),
      .req_class_code   (req_class_code),
      .req_det_score    (req_det_score),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_report_kind  (rsp_report_kind),
      .rsp_out_track_id (rsp_out_track_id),
      .rsp_identified   (rsp_identified),
      .rsp_out_class    (rsp_out_class),
      .rsp_out_score    (rsp_out_score),
      .rsp_matched_det  (rsp_matched_det),
      .rsp_overflowed   (rsp_overflowed),
      .rsp_last         (rsp_last),
      .csr_write        (csr_valid && csr_ready),
      .csr_data         (csr_data)
   );

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the track label fusion block: frames of random and
// directed boxes are driven with random gaps and stalls, and every report is
// compared with a behavioural prediction of the greedy IoU association.
// ----------------------------------------------------------------------------
module tb;
   import gitlf_pkg::*;

   localparam int NT = 16;
   localparam int ND = 16;
   localparam int NID = 256;
   localparam int WATCH_LIMIT = 400000;
   localparam int HOLD_CYCLES = 3000;

   typedef struct packed {
      logic [1:0]  kind;
      logic [11:0] left;
      logic [11:0] top;
      logic [11:0] width;
      logic [11:0] height;
      logic        has_box;
      logic [7:0]  track_id;
      logic [7:0]  class_code;
      logic [15:0] score;
   } req_item_type;

   typedef struct packed {
      logic        report_kind;
      logic [7:0]  track_id;
      logic        identified;
      logic [7:0]  class_code;
      logic [15:0] score;
      logic [4:0]  matched_det;
      logic        overflowed;
      logic        last;
   } report_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_item_type drv = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b1;
   report_type got;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [15:0] csr_data = '0;

   greedy_iou_track_label_fusion uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_kind(drv.kind), .req_box_left(drv.left), .req_box_top(drv.top),
      .req_box_width(drv.width), .req_box_height(drv.height),
      .req_has_box(drv.has_box), .req_track_id(drv.track_id),
      .req_class_code(drv.class_code), .req_det_score(drv.score),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_report_kind(got.report_kind), .rsp_out_track_id(got.track_id),
      .rsp_identified(got.identified), .rsp_out_class(got.class_code),
      .rsp_out_score(got.score), .rsp_matched_det(got.matched_det),
      .rsp_overflowed(got.overflowed), .rsp_last(got.last),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // predictor state
   logic [15:0] thr_m;
   req_item_type trk_m[NT];
   int          trk_n;
   req_item_type det_m[ND];
   int          det_n;
   logic        lab_ok[NID];
   logic [7:0]  lab_cls[NID];
   logic [15:0] lab_scr[NID];
   logic        was_live[NID];
   logic        ovf_m;

   req_item_type pending[$];
   report_type   expected_reports[$];
   int  fails = 0;
   int  idle_cycles = 0;
   int  gap_left = 0;
   int  stall_left = 0;
   int  drv_draw;
   int  rsp_draw;
   logic holding = 1'b0;
   event hold_go;
   logic all_sent = 1'b0;

   function automatic logic [47:0] overlap(input logic [12:0] a0, a1, b0, b1);
      logic [12:0] lo, hi;
      lo = a0 > b0 ? a0 : b0;
      hi = a1 < b1 ? a1 : b1;
      return hi > lo ? 48'(hi - lo) : 48'd0;
   endfunction

   task automatic add_item(input req_item_type it);
      pending = {pending, it};
   endtask

   task automatic add_report(input report_type r);
      expected_reports = {expected_reports, r};
   endtask

   task automatic predict_frame();
      logic        live[NID];
      logic [47:0] inter[NT][ND];
      logic [47:0] uni[NT][ND];
      logic        ok[NT][ND];
      int          asg[NT];
      logic [ND-1:0] used;
      logic        found;
      int          bi, bj, idx, d;
      logic [47:0] ix, iy, at, ad;
      report_type  r;
      int          first;
      first = expected_reports.size();
      for (int i = 0; i < NID; i++) live[i] = 1'b0;
      for (int i = 0; i < trk_n; i++) live[trk_m[i].track_id] = 1'b1;
      for (int i = 0; i < NID; i++) begin
         if (was_live[i] && !live[i]) begin
            lab_ok[i] = 1'b0; lab_cls[i] = '0; lab_scr[i] = '0;
            r = '{REPORT_VANISH, 8'(i), 1'b0, 8'd0, 16'd0, 5'(ND), ovf_m, 1'b0};
            add_report(r);
         end
         was_live[i] = live[i];
      end
      for (int i = 0; i < trk_n; i++) begin
         for (int j = 0; j < det_n; j++) begin
            ix = overlap(trk_m[i].left, trk_m[i].left + trk_m[i].width,
                         det_m[j].left, det_m[j].left + det_m[j].width);
            iy = overlap(trk_m[i].top, trk_m[i].top + trk_m[i].height,
                         det_m[j].top, det_m[j].top + det_m[j].height);
            at = trk_m[i].width * trk_m[i].height;
            ad = det_m[j].width * det_m[j].height;
            inter[i][j] = ix * iy;
            uni[i][j] = at + ad - inter[i][j];
            ok[i][j] = trk_m[i].has_box &&
                       ({inter[i][j], 16'd0} > 64'(thr_m) * 64'(uni[i][j]));
         end
         asg[i] = ND;
      end
      used = '0;
      forever begin
         found = 1'b0; bi = 0; bj = 0;
         for (int i = 0; i < trk_n; i++) begin
            if (asg[i] != ND) continue;
            for (int j = 0; j < det_n; j++) begin
               if (!ok[i][j] || used[j]) continue;
               if (!found || 96'(inter[i][j]) * uni[bi][bj] >
                             96'(inter[bi][bj]) * uni[i][j]) begin
                  found = 1'b1; bi = i; bj = j;
               end
            end
         end
         if (!found) break;
         asg[bi] = bj;
         used[bj] = 1'b1;
      end
      for (int i = 0; i < trk_n; i++) begin
         idx = trk_m[i].track_id;
         d = asg[i];
         if (d < det_n && det_m[d].score > lab_scr[idx]) begin
            lab_ok[idx] = 1'b1;
            lab_cls[idx] = det_m[d].class_code;
            lab_scr[idx] = det_m[d].score;
         end
         r = '{REPORT_LIVE, trk_m[i].track_id, lab_ok[idx],
               lab_ok[idx] ? lab_cls[idx] : 8'd0,
               lab_ok[idx] ? lab_scr[idx] : 16'd0, 5'(d), ovf_m, 1'b0};
         add_report(r);
      end
      if (expected_reports.size() > first)
         expected_reports[$].last = 1'b1;
      trk_n = 0;
      ovf_m = 1'b0;
   endtask

   task automatic predict_item(input req_item_type it);
      case (it.kind)
         KIND_TRACK: if (trk_n < NT) begin trk_m[trk_n] = it; trk_n++; end
                     else ovf_m = 1'b1;
         KIND_DET:   if (det_n < ND) begin det_m[det_n] = it; det_n++; end
                     else ovf_m = 1'b1;
         KIND_EOF:   predict_frame();
         default:    det_n = 0;
      endcase
   endtask

   // driver
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            predict_item(drv);
            void'(pending.pop_front());
            drv_draw = $urandom_range(0, 5);
            if (drv_draw == 0 && pending.size() > 0) begin
               drv <= pending[0];
               gap_left <= 0;
            end else begin
               gap_left <= (drv_draw > 0) ? drv_draw - 1 : 0;
               req_valid <= 1'b0;
            end
         end else if (!req_valid) begin
            if (gap_left > 0) gap_left <= gap_left - 1;
            else if (pending.size() > 0) begin
               drv <= pending[0];
               req_valid <= 1'b1;
            end
         end
      end
   end

   // long receiver hold-off, counted here
   always begin
      @(hold_go);
      holding <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      holding <= 1'b0;
   end

   // monitor and receiver stall
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_reports.size() == 0) begin
               $error("unexpected report id=%0d", got.track_id);
               fails++;
            end else begin
               report_type e;
               e = expected_reports.pop_front();
               if (e.report_kind != got.report_kind) begin
                  $error("report_kind exp %0d got %0d", e.report_kind, got.report_kind);
                  fails++;
               end
               if (e.track_id != got.track_id) begin
                  $error("out_track_id exp %0d got %0d", e.track_id, got.track_id);
                  fails++;
               end
               if (e.identified != got.identified) begin
                  $error("identified exp %0d got %0d", e.identified, got.identified);
                  fails++;
               end
               if (e.class_code != got.class_code) begin
                  $error("out_class exp %0d got %0d", e.class_code, got.class_code);
                  fails++;
               end
               if (e.score != got.score) begin
                  $error("out_score exp %0d got %0d", e.score, got.score);
                  fails++;
               end
               if (e.matched_det != got.matched_det) begin
                  $error("matched_det exp %0d got %0d", e.matched_det, got.matched_det);
                  fails++;
               end
               if (e.overflowed != got.overflowed) begin
                  $error("overflowed exp %0d got %0d", e.overflowed, got.overflowed);
                  fails++;
               end
               if (e.last != got.last) begin
                  $error("last exp %0d got %0d", e.last, got.last);
                  fails++;
               end
            end
         end
         if (holding) begin
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_stall <= 1'b1;
         end else if (rsp_valid && !rsp_stall) begin
            rsp_draw = $urandom_range(0, 5);
            stall_left <= (rsp_draw > 0) ? rsp_draw - 1 : 0;
            rsp_stall <= (rsp_draw > 0);
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         idle_cycles <= 0;
      else if (!all_sent || expected_reports.size() > 0) begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCH_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   function automatic req_item_type rand_box(input logic [1:0] k, input int span);
      req_item_type it;
      it = '0;
      it.kind = k;
      it.left = 12'($urandom_range(0, span));
      it.top = 12'($urandom_range(0, span));
      it.width = 12'($urandom_range(1, span));
      it.height = 12'($urandom_range(1, span));
      it.has_box = ($urandom_range(0, 9) != 0);
      it.track_id = 8'($urandom_range(0, 23));
      it.class_code = 8'($urandom);
      it.score = 16'($urandom);
      if ($urandom_range(0, 15) == 0) begin
         it.left = 12'($urandom); it.top = 12'($urandom);
         it.width = 12'($urandom); it.height = 12'($urandom);
         it.track_id = 8'($urandom);
      end
      return it;
   endfunction

   function automatic req_item_type mk(input logic [1:0] k, input int l, t, w, h,
                                       input int id, cls, sc, input logic hb);
      req_item_type it;
      it = '{k, 12'(l), 12'(t), 12'(w), 12'(h), hb, 8'(id), 8'(cls), 16'(sc)};
      return it;
   endfunction

   task automatic run_frames(input int frames);
      int nt, nd;
      req_item_type b;
      for (int f = 0; f < frames; f++) begin
         if ($urandom_range(0, 2) == 0) begin
            add_item(mk(KIND_BATCH, 0, 0, 0, 0, 0, 0, 0, 1'b0));
            nd = $urandom_range(0, 6);
            if ($urandom_range(0, 12) == 0) nd = 18;
            for (int j = 0; j < nd; j++) add_item(rand_box(KIND_DET, 300));
         end
         nt = $urandom_range(0, 6);
         if ($urandom_range(0, 12) == 0) nt = 18;
         for (int i = 0; i < nt; i++) begin
            b = rand_box(KIND_TRACK, 300);
            // often widen a track box to at least 40 each way so pairs match more often
            if (det_n > 0 || $urandom_range(0, 1)) begin
               b.width = b.width | 12'd40;
               b.height = b.height | 12'd40;
            end
            add_item(b);
         end
         add_item(mk(KIND_EOF, 0, 0, 0, 0, 0, 0, 0, 1'b0));
      end
   endtask

   task automatic drain();
      all_sent = 1'b1;
      while (pending.size() > 0 || req_valid || expected_reports.size() > 0)
         @(posedge clock);
      repeat (200) @(posedge clock);
      all_sent = 1'b0;
   endtask

   task automatic write_threshold(input logic [15:0] v);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= v;
      do @(posedge clock); while (!csr_ready);
      thr_m = v;
      csr_valid <= 1'b0;
   endtask

   initial begin
      thr_m = THR_RESET;
      trk_n = 0; det_n = 0; ovf_m = 1'b0;
      for (int i = 0; i < NID; i++) begin
         lab_ok[i] = 1'b0; lab_cls[i] = '0; lab_scr[i] = '0; was_live[i] = 1'b0;
      end
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: matches, exact tie, zero score, no box, extreme fields
      add_item(mk(KIND_DET, 100, 100, 50, 50, 0, 7, 1000, 1'b1));
      add_item(mk(KIND_DET, 100, 100, 50, 50, 0, 9, 0, 1'b1));
      add_item(mk(KIND_DET, 4095, 4095, 4095, 4095, 255, 255, 65535, 1'b1));
      add_item(mk(KIND_TRACK, 100, 100, 50, 50, 3, 0, 0, 1'b1));
      add_item(mk(KIND_TRACK, 100, 100, 50, 50, 3, 0, 0, 1'b1));
      add_item(mk(KIND_TRACK, 4095, 4095, 4095, 4095, 255, 255, 65535, 1'b1));
      add_item(mk(KIND_TRACK, 100, 100, 50, 50, 0, 0, 0, 1'b0));
      add_item(mk(KIND_EOF, 4095, 4095, 4095, 4095, 255, 255, 65535, 1'b1));
      add_item(mk(KIND_TRACK, 0, 0, 0, 0, 3, 0, 0, 1'b1));
      add_item(mk(KIND_EOF, 0, 0, 0, 0, 0, 0, 0, 1'b0));
      add_item(mk(KIND_EOF, 0, 0, 0, 0, 0, 0, 0, 1'b0));
      add_item(mk(KIND_BATCH, 4095, 4095, 4095, 4095, 255, 255, 65535, 1'b1));
      add_item(mk(KIND_TRACK, 10, 10, 20, 20, 128, 0, 0, 1'b1));
      add_item(mk(KIND_EOF, 0, 0, 0, 0, 0, 0, 0, 1'b0));
      drain();

      // random frames at several thresholds, extremes included
      run_frames(7);
      drain();
      write_threshold(16'd0);
      run_frames(5);
      drain();
      write_threshold(16'hffff);
      run_frames(3);
      drain();
      write_threshold(16'd40000);
      // long receiver hold-off while the sender keeps offering items
      run_frames(4);
      -> hold_go;
      drain();
      write_threshold(THR_RESET);
      run_frames(5);
      drain();

      if (fails == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end
endmodule

>>> files.f
rtl/gitlf_pkg.sv
rtl/gitlf_ram.sv
rtl/gitlf_ctrl.sv
rtl/gitlf_dp.sv
rtl/greedy_iou_track_label_fusion.sv
sim/tb.sv
